// ===== hdl/gpc_pkg.sv =====
// Shared types, constants and the pin decode function of the GPIO pin controller.
package gpc_pkg;

	localparam int NUM_BANKS     = 8;
	localparam int PINS_PER_BANK = 32;
	localparam int STORE_DEPTH   = NUM_BANKS * PINS_PER_BANK;
	localparam int BANK_W        = $clog2(NUM_BANKS);
	localparam int BPIN_W        = $clog2(PINS_PER_BANK);
	localparam int IDX_W         = $clog2(STORE_DEPTH);

	// Port sizes in bank order A, B, C, D, E, F, G, L. Bank B carries no pins.
	localparam logic [6:0] BANK_SIZE [NUM_BANKS] = '{
		7'd22, 7'd0, 7'd17, 7'd18, 7'd16, 7'd7, 7'd14, 7'd12
	};

	localparam logic [6:0] PWM_PIN_A = 7'd5;
	localparam logic [6:0] PWM_PIN_B = 7'd6;
	localparam logic [6:0] PWM_PIN_L = 7'd104;

	localparam logic [2:0] MODE_ALT2     = 3'd2;
	localparam logic [2:0] MODE_ALT3     = 3'd3;
	localparam logic [2:0] MODE_DISABLED = 3'd7;
	localparam logic [3:0] MODE_PWM      = 4'd8;
	localparam logic [1:0] PULL_KEEP     = 2'd3;

	typedef enum logic [2:0] {
		ACT_READ_MODE  = 3'd0,
		ACT_SET_MODE   = 3'd1,
		ACT_READ_PULL  = 3'd2,
		ACT_SET_PULL   = 3'd3,
		ACT_WRITE_LVL  = 3'd4,
		ACT_TOGGLE_LVL = 3'd5,
		ACT_READ_LVL   = 3'd6
	} action_t;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_RANGE      = 2'd1,
		ST_PWM_DENIED = 2'd2
	} status_t;

	typedef struct packed {
		logic [2:0] mode;
		logic [1:0] pull;
		logic       level;
	} entry_t;

	localparam int     ENTRY_W     = $bits(entry_t);
	localparam entry_t RESET_ENTRY = '{mode: MODE_DISABLED, pull: 2'd0, level: 1'b0};

	typedef struct packed {
		logic [3:0] mode_out;
		logic [1:0] pull_out;
		logic       level_out;
		status_t    status;
	} result_t;

	typedef struct packed {
		logic             ok;
		logic [IDX_W-1:0] idx;
	} decode_t;

	// Walks the port sizes in turn; the index is bank * PINS_PER_BANK + pin within bank.
	function automatic decode_t decode_pin(input logic [6:0] pin);
		decode_t    d;
		logic [6:0] rest;
		d.ok  = 1'b0;
		d.idx = '0;
		rest  = pin;
		for (int b = 0; b < NUM_BANKS; b++) begin
			if (!d.ok) begin
				if (rest < BANK_SIZE[b]) begin
					d.ok  = 1'b1;
					d.idx = {b[BANK_W-1:0], rest[BPIN_W-1:0]};
				end else begin
					rest = rest - BANK_SIZE[b];
				end
			end
		end
		return d;
	endfunction

endpackage

// ===== hdl/gpc_req_if.sv =====
// Request channel interface of the GPIO pin controller.
interface gpc_req_if;
	logic       valid;
	logic       ready;
	logic [2:0] action;
	logic [6:0] pin;
	logic [3:0] mode_value;
	logic [1:0] pull_value;
	logic       level;

	modport source (output valid, action, pin, mode_value, pull_value, level, input ready);
	modport sink   (input valid, action, pin, mode_value, pull_value, level, output ready);
endinterface

// ===== hdl/gpc_rsp_if.sv =====
// Response channel interface of the GPIO pin controller.
interface gpc_rsp_if;
	logic       valid;
	logic       ready;
	logic [3:0] mode_out;
	logic [1:0] pull_out;
	logic       level_out;
	logic [1:0] status;

	modport source (output valid, mode_out, pull_out, level_out, status, input ready);
	modport sink   (input valid, mode_out, pull_out, level_out, status, output ready);
endinterface

// ===== hdl/gpc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module gpc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end
endmodule

// ===== hdl/gpc_update.sv =====
// Per-action update of one pin entry and formation of the result fields.
module gpc_update import gpc_pkg::*; (
	input  logic [2:0] action,
	input  logic [6:0] pin,
	input  logic [3:0] mode_value,
	input  logic [1:0] pull_value,
	input  logic       level,
	input  logic       in_range,
	input  entry_t     cur,
	output entry_t     nxt,
	output result_t    res
);
	status_t    status;
	logic       pwm_pin_a;
	logic       pwm_pin_l;
	logic [3:0] shown_mode;

	assign pwm_pin_a = (pin == PWM_PIN_A) || (pin == PWM_PIN_B);
	assign pwm_pin_l = (pin == PWM_PIN_L);

	always_comb begin
		nxt    = cur;
		status = ST_OK;
		case (action)
			ACT_SET_MODE: begin
				if (mode_value == MODE_PWM) begin
					if (pwm_pin_a) begin
						nxt.mode = MODE_ALT3;
					end else if (pwm_pin_l) begin
						nxt.mode = MODE_ALT2;
					end else begin
						status = ST_PWM_DENIED;
					end
				end else if (mode_value < MODE_PWM) begin
					nxt.mode = mode_value[2:0];
				end
			end
			ACT_SET_PULL: begin
				if (pull_value != PULL_KEEP) begin
					nxt.pull = pull_value;
				end
			end
			ACT_WRITE_LVL:  nxt.level = level;
			ACT_TOGGLE_LVL: nxt.level = ~cur.level;
			default: ;
		endcase
	end

	// Pins wired to the PWM block report PWM while they sit in that alternate function.
	always_comb begin
		if ((nxt.mode == MODE_ALT3 && pwm_pin_a) || (nxt.mode == MODE_ALT2 && pwm_pin_l)) begin
			shown_mode = MODE_PWM;
		end else begin
			shown_mode = {1'b0, nxt.mode};
		end
	end

	always_comb begin
		if (in_range) begin
			res.mode_out  = shown_mode;
			res.pull_out  = nxt.pull;
			res.level_out = nxt.level;
			res.status    = status;
		end else begin
			res.mode_out  = '0;
			res.pull_out  = '0;
			res.level_out = 1'b0;
			res.status    = ST_RANGE;
		end
	end
endmodule

// ===== hdl/gpio_port_pin_controller.sv =====
// Top level of the GPIO pin controller: decode, pin store, update and response register.
// A request waits in stage s1 for its store read, then its result goes to the response register.
// Throughput: one transaction per cycle unless rsp stalls; one store read-modify-write each.
// The store is a RAM with registered read; a write-forward register covers back-to-back
// accesses to the same pin.
// Reset clears per-entry valid bits, so every pin reads as disabled, pull off, level low at once.
module gpio_port_pin_controller import gpc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	gpc_req_if.sink  req,
	gpc_rsp_if.source rsp
);
	decode_t              dec;
	logic                 accept;
	logic                 adv;

	logic                 valid_s1;
	logic [2:0]           action_s1;
	logic [6:0]           pin_s1;
	logic [3:0]           mode_value_s1;
	logic [1:0]           pull_value_s1;
	logic                 level_s1;
	logic                 in_range_s1;
	logic [IDX_W-1:0]     idx_s1;
	logic                 ent_vld_s1;

	logic [STORE_DEPTH-1:0] ent_vld_q;
	logic                 fwd_vld_q;
	logic [IDX_W-1:0]     fwd_idx_q;
	entry_t               fwd_data_q;

	logic [ENTRY_W-1:0]   ram_rd;
	entry_t               cur;
	entry_t               nxt;
	result_t              res;
	logic                 wr_en;

	logic                 out_vld_q;
	result_t              out_q;

	assign dec    = decode_pin(req.pin);
	assign accept = req.valid && req.ready;
	assign adv    = valid_s1 && (!out_vld_q || rsp.ready);
	assign req.ready = !valid_s1 || adv;
	assign wr_en  = adv && in_range_s1;

	gpc_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (STORE_DEPTH)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (idx_s1),
		.wr_data (nxt),
		.rd_en   (accept),
		.rd_addr (dec.idx),
		.rd_data (ram_rd)
	);

	// The latest write always matches the store for its index, so it may be used whenever it hits.
	always_comb begin
		if (fwd_vld_q && fwd_idx_q == idx_s1) begin
			cur = fwd_data_q;
		end else if (ent_vld_s1) begin
			cur = entry_t'(ram_rd);
		end else begin
			cur = RESET_ENTRY;
		end
	end

	gpc_update u_update (
		.action     (action_s1),
		.pin        (pin_s1),
		.mode_value (mode_value_s1),
		.pull_value (pull_value_s1),
		.level      (level_s1),
		.in_range   (in_range_s1),
		.cur        (cur),
		.nxt        (nxt),
		.res        (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			action_s1     <= req.action;
			pin_s1        <= req.pin;
			mode_value_s1 <= req.mode_value;
			pull_value_s1 <= req.pull_value;
			level_s1      <= req.level;
			in_range_s1   <= dec.ok;
			idx_s1        <= dec.idx;
			ent_vld_s1    <= ent_vld_q[dec.idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_vld_q <= '0;
			fwd_vld_q <= 1'b0;
		end else if (wr_en) begin
			ent_vld_q[idx_s1] <= 1'b1;
			fwd_vld_q         <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			fwd_idx_q  <= idx_s1;
			fwd_data_q <= nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q <= res;
		end
	end

	assign rsp.valid     = out_vld_q;
	assign rsp.mode_out  = out_q.mode_out;
	assign rsp.pull_out  = out_q.pull_out;
	assign rsp.level_out = out_q.level_out;
	assign rsp.status    = out_q.status;
endmodule

// ===== hdl/gpc_checker.sv =====
// Port-level checks of the GPIO pin controller and their bind to the top level.
module gpc_checker import gpc_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       req_valid,
	input logic       req_ready,
	input logic       rsp_valid,
	input logic       rsp_ready,
	input logic [3:0] mode_out,
	input logic [1:0] pull_out,
	input logic       level_out,
	input logic [1:0] status
);
	// A waiting response keeps its contents until it is taken.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(mode_out) && $stable(pull_out)
			&& $stable(level_out) && $stable(status))
		else $error("response changed while stalled");

	// Every accepted request is followed by a shown response.
	a_rsp_follows: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |-> ##2 rsp_valid)
		else $error("no response after accepted request");

	// An out-of-range pin reports all-zero pin fields.
	a_range_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == ST_RANGE |-> mode_out == 4'd0 && pull_out == 2'd0
			&& level_out == 1'b0)
		else $error("out-of-range response carries pin state");

	// PWM can only be shown on a pin that accepts it, so it never pairs with a rejection.
	a_pwm_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && mode_out == MODE_PWM |-> status == ST_OK)
		else $error("PWM mode reported with non-ok status");
endmodule

bind gpio_port_pin_controller gpc_checker u_gpc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.mode_out  (rsp.mode_out),
	.pull_out  (rsp.pull_out),
	.level_out (rsp.level_out),
	.status    (rsp.status)
);

// ===== tb/gpio_port_pin_controller_test.sv =====
// Self-checking testbench of the GPIO pin controller: directed table, then random pin accesses.
module gpio_port_pin_controller_test;
	import gpc_pkg::*;

	localparam int LIMIT_CYCLES = 200000;
	localparam int HOLD_CYCLES  = 300;
	localparam int DIR_N        = 25;
	localparam int PHASE_ITEMS  = 100;

	localparam logic [2:0] ACT_IDLE = 3'd7;

	localparam logic [3:0] M_INPUT    = 4'd0;
	localparam logic [3:0] M_OUTPUT   = 4'd1;
	localparam logic [3:0] M_ALT2     = 4'd2;
	localparam logic [3:0] M_ALT3     = 4'd3;
	localparam logic [3:0] M_ALT6     = 4'd6;
	localparam logic [3:0] M_DISABLED = 4'd7;
	localparam logic [3:0] M_BAD_LO   = 4'd9;
	localparam logic [3:0] M_BAD_HI   = 4'd15;

	localparam logic [1:0] PULL_OFF  = 2'd0;
	localparam logic [1:0] PULL_UP   = 2'd1;
	localparam logic [1:0] PULL_DOWN = 2'd2;

	localparam result_t R_NONE   = '{M_INPUT, PULL_OFF, 1'b0, ST_OK};
	localparam result_t R_RANGE  = '{M_INPUT, PULL_OFF, 1'b0, ST_RANGE};
	localparam result_t R_RESET  = '{M_DISABLED, PULL_OFF, 1'b0, ST_OK};
	localparam result_t R_DENIED = '{M_DISABLED, PULL_OFF, 1'b0, ST_PWM_DENIED};
	localparam result_t R_PWM    = '{MODE_PWM, PULL_OFF, 1'b0, ST_OK};

	localparam logic [6:0] HOT_PINS [7] = '{7'd5, 7'd6, 7'd104, 7'd0, 7'd105, 7'd21, 7'd22};

	typedef struct {
		logic [2:0] action;
		logic [6:0] pin;
		logic [3:0] mode_value;
		logic [1:0] pull_value;
		logic       level;
		bit         typed;
		result_t    want;
	} dir_row_t;

	logic clk;
	logic arst_n;

	gpc_req_if req_ch ();
	gpc_rsp_if rsp_ch ();

	gpio_port_pin_controller uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	logic [2:0] mode_mem  [STORE_DEPTH];
	logic [1:0] pull_mem  [STORE_DEPTH];
	logic       level_mem [STORE_DEPTH];

	result_t  pending_results [$];
	dir_row_t dir_rows [DIR_N];
	int       err_count    = 0;
	int       results_seen = 0;
	int       cycle_count  = 0;
	bit       snd_busy     = 0;
	bit       rcv_busy     = 0;
	bit       hold_rsp     = 0;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Walks the port sizes; bank B has size zero and is passed over.
	function automatic bit locate_pin(input logic [6:0] pin, output int unsigned slot);
		int  rest;
		int  b;
		bit  hit;
		rest = int'(pin);
		hit  = 1'b0;
		slot = 0;
		for (b = 0; b < NUM_BANKS; b++) begin
			if (!hit) begin
				if (rest < int'(BANK_SIZE[b])) begin
					hit  = 1'b1;
					slot = unsigned'(b * PINS_PER_BANK + rest);
				end else begin
					rest = rest - int'(BANK_SIZE[b]);
				end
			end
		end
		return hit;
	endfunction

	function automatic result_t apply_pin_access(input logic [2:0] act, input logic [6:0] pin,
			input logic [3:0] mv, input logic [1:0] pv, input logic lv);
		int unsigned slot;
		logic [2:0]  stored;
		result_t     r;
		if (!locate_pin(pin, slot))
			return R_RANGE;
		r.status = ST_OK;
		case (act)
			ACT_SET_MODE: begin
				if (mv == MODE_PWM) begin
					if (pin == PWM_PIN_A || pin == PWM_PIN_B)
						mode_mem[slot] = MODE_ALT3;
					else if (pin == PWM_PIN_L)
						mode_mem[slot] = MODE_ALT2;
					else
						r.status = ST_PWM_DENIED;
				end else if (mv < MODE_PWM) begin
					mode_mem[slot] = mv[2:0];
				end
			end
			ACT_SET_PULL: begin
				if (pv != PULL_KEEP)
					pull_mem[slot] = pv;
			end
			ACT_WRITE_LVL:  level_mem[slot] = lv;
			ACT_TOGGLE_LVL: level_mem[slot] = ~level_mem[slot];
			default: ;
		endcase
		stored     = mode_mem[slot];
		r.mode_out = {1'b0, stored};
		// The PWM pins in their PWM alternate function read back as PWM.
		if ((stored == MODE_ALT3 && (pin == PWM_PIN_A || pin == PWM_PIN_B)) ||
				(stored == MODE_ALT2 && pin == PWM_PIN_L))
			r.mode_out = MODE_PWM;
		r.pull_out  = pull_mem[slot];
		r.level_out = level_mem[slot];
		return r;
	endfunction

	// Offers one request and, once the transaction is taken, queues its expected response.
	task automatic send_req(input logic [2:0] act, input logic [6:0] pin, input logic [3:0] mv,
			input logic [1:0] pv, input logic lv, input bit typed, input result_t want);
		int      gap;
		result_t predicted;
		gap = snd_busy ? 0 : $urandom_range(0, 18);
		if (gap != 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.valid      <= 1'b1;
		req_ch.action     <= act;
		req_ch.pin        <= pin;
		req_ch.mode_value <= mv;
		req_ch.pull_value <= pv;
		req_ch.level      <= lv;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		predicted = apply_pin_access(act, pin, mv, pv, lv);
		pending_results.push_back(typed ? want : predicted);
		@(negedge clk);
	endtask

	always @(posedge clk) begin
		result_t want;
		if (arst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
			results_seen <= results_seen + 1;
			if (pending_results.size() == 0) begin
				if (err_count < 10)
					$display("response with nothing expected: mode %0d pull %0d level %0d status %0d",
						rsp_ch.mode_out, rsp_ch.pull_out, rsp_ch.level_out, rsp_ch.status);
				err_count <= err_count + 1;
			end else begin
				want = pending_results.pop_front();
				if (rsp_ch.mode_out !== want.mode_out || rsp_ch.pull_out !== want.pull_out ||
						rsp_ch.level_out !== want.level_out || rsp_ch.status !== want.status) begin
					if (err_count < 10)
						$display("mismatch: expected mode %0d pull %0d level %0d status %0d, %s %0d %0d %0d %0d",
							want.mode_out, want.pull_out, want.level_out, want.status,
							"got", rsp_ch.mode_out, rsp_ch.pull_out, rsp_ch.level_out,
							rsp_ch.status);
					err_count <= err_count + 1;
				end
			end
		end
	end

	// Response side: random stalls, and one long hold-off on request.
	initial begin
		int gap;
		int seen;
		rsp_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if (hold_rsp) begin
				gap      = HOLD_CYCLES;
				hold_rsp = 1'b0;
			end else begin
				gap = rcv_busy ? 0 : $urandom_range(0, 18);
			end
			if (gap != 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			rsp_ch.ready <= 1'b1;
			seen = results_seen;
			do @(negedge clk); while (results_seen == seen);
		end
	end

	initial begin
		int         k;
		int         phase;
		int         roll;
		logic [2:0] act;
		logic [6:0] pin;
		logic [6:0] last_pin;
		logic [3:0] mv;

		arst_n            = 1'b0;
		req_ch.valid      = 1'b0;
		req_ch.action     = ACT_READ_MODE;
		req_ch.pin        = '0;
		req_ch.mode_value = M_INPUT;
		req_ch.pull_value = PULL_OFF;
		req_ch.level      = 1'b0;
		for (k = 0; k < STORE_DEPTH; k++) begin
			mode_mem[k]  = MODE_DISABLED;
			pull_mem[k]  = PULL_OFF;
			level_mem[k] = 1'b0;
		end

		dir_rows = '{
			'{ACT_READ_MODE,  7'd0,   M_INPUT,    PULL_OFF,  1'b0, 1'b1, R_RESET},
			'{ACT_READ_PULL,  7'd105, M_INPUT,    PULL_OFF,  1'b0, 1'b1, R_RESET},
			'{ACT_READ_LVL,   7'd106, M_INPUT,    PULL_OFF,  1'b0, 1'b1, R_RANGE},
			'{ACT_SET_MODE,   7'd127, M_OUTPUT,   PULL_KEEP, 1'b1, 1'b1, R_RANGE},
			'{ACT_SET_MODE,   7'd0,   MODE_PWM,   PULL_OFF,  1'b0, 1'b1, R_DENIED},
			'{ACT_SET_MODE,   7'd5,   MODE_PWM,   PULL_OFF,  1'b0, 1'b1, R_PWM},
			'{ACT_SET_MODE,   7'd6,   MODE_PWM,   PULL_OFF,  1'b0, 1'b1, R_PWM},
			'{ACT_SET_MODE,   7'd104, MODE_PWM,   PULL_OFF,  1'b0, 1'b1, R_PWM},
			'{ACT_SET_MODE,   7'd5,   M_BAD_HI,   PULL_KEEP, 1'b1, 1'b1, R_PWM},
			'{ACT_READ_MODE,  7'd6,   M_INPUT,    PULL_OFF,  1'b0, 1'b0, R_NONE},
			'{ACT_SET_MODE,   7'd104, M_ALT3,     PULL_OFF,  1'b0, 1'b0, R_NONE},
			'{ACT_SET_MODE,   7'd6,   M_ALT2,     PULL_OFF,  1'b0, 1'b0, R_NONE},
			'{ACT_SET_MODE,   7'd21,  M_INPUT,    PULL_OFF,  1'b0, 1'b0, R_NONE},
			'{ACT_SET_MODE,   7'd22,  M_ALT6,     PULL_OFF,  1'b0, 1'b0, R_NONE},
			'{ACT_SET_PULL,   7'd22,  M_INPUT,    PULL_DOWN, 1'b0, 1'b0, R_NONE},
			'{ACT_SET_PULL,   7'd22,  M_INPUT,    PULL_KEEP, 1'b0, 1'b0, R_NONE},
			'{ACT_READ_PULL,  7'd22,  M_INPUT,    PULL_OFF,  1'b0, 1'b0, R_NONE},
			'{ACT_SET_PULL,   7'd105, M_INPUT,    PULL_UP,   1'b0, 1'b0, R_NONE},
			'{ACT_WRITE_LVL,  7'd105, M_INPUT,    PULL_OFF,  1'b1, 1'b0, R_NONE},
			'{ACT_TOGGLE_LVL, 7'd105, M_INPUT,    PULL_OFF,  1'b0, 1'b0, R_NONE},
			'{ACT_TOGGLE_LVL, 7'd0,   M_INPUT,    PULL_OFF,  1'b0, 1'b0, R_NONE},
			'{ACT_READ_LVL,   7'd105, M_INPUT,    PULL_OFF,  1'b0, 1'b0, R_NONE},
			'{ACT_IDLE,       7'd38,  M_BAD_LO,   PULL_KEEP, 1'b1, 1'b0, R_NONE},
			'{ACT_IDLE,       7'd120, M_INPUT,    PULL_OFF,  1'b0, 1'b1, R_RANGE},
			'{ACT_SET_MODE,   7'd39,  M_OUTPUT,   PULL_OFF,  1'b1, 1'b0, R_NONE}
		};

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		for (k = 0; k < DIR_N; k++)
			send_req(dir_rows[k].action, dir_rows[k].pin, dir_rows[k].mode_value,
				dir_rows[k].pull_value, dir_rows[k].level, dir_rows[k].typed, dir_rows[k].want);

		// Phase 1 runs with no idling on either side; phase 2 holds the responses off
		// while requests keep coming, then waits for the block to drain.
		last_pin = 7'd0;
		for (phase = 0; phase < 4; phase++) begin
			snd_busy = (phase == 1) || (phase == 2);
			rcv_busy = (phase == 1);
			if (phase == 2)
				hold_rsp = 1'b1;
			for (k = 0; k < PHASE_ITEMS; k++) begin
				roll = $urandom_range(0, 99);
				if (roll < 10)
					pin = 7'($urandom_range(106, 127));
				else if (roll < 30)
					pin = HOT_PINS[$urandom_range(0, 6)];
				else if (roll < 45)
					pin = last_pin;
				else
					pin = 7'($urandom_range(0, 105));
				last_pin = pin;
				act = ($urandom_range(0, 99) < 5) ? ACT_IDLE : 3'($urandom_range(0, 6));
				roll = $urandom_range(0, 99);
				if (roll < 12)
					mv = 4'($urandom_range(9, 15));
				else if (roll < 25)
					mv = MODE_PWM;
				else
					mv = 4'($urandom_range(0, 8));
				send_req(act, pin, mv, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
					1'b0, R_NONE);
			end
			if (phase == 2) begin
				req_ch.valid <= 1'b0;
				while (pending_results.size() != 0)
					@(negedge clk);
			end
		end

		req_ch.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
		if (pending_results.size() != 0)
			err_count = err_count + 1;
		if (err_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// ===== gpio_port_pin_controller.f =====
hdl/gpc_pkg.sv
hdl/gpc_req_if.sv
hdl/gpc_rsp_if.sv
hdl/gpc_ram.sv
hdl/gpc_update.sv
hdl/gpio_port_pin_controller.sv
hdl/gpc_checker.sv
tb/gpio_port_pin_controller_test.sv
